### rtl/core/palette_blend_bleed_pixel_stream_assert.svh
// Assertion macros shared by the checker of the palette blend and bleed pixel stream.
`ifndef PALETTE_BLEND_BLEED_PIXEL_STREAM_ASSERT_SVH
`define PALETTE_BLEND_BLEED_PIXEL_STREAM_ASSERT_SVH

// General property check on the rising clock edge, off while reset is asserted.
`define PBB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A beat that is offered but not taken must keep its payload for the next cycle.
`define PBB_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy) |=> $stable(sig))) else $error(msg);

`endif

### rtl/core/pbb_pkg.sv
// Package with types, constants and the byte averaging function of the pixel path.
`default_nettype none

package pbb_pkg;

	localparam int PALETTE_ENTRIES_DEF = 32768;
	localparam int INDEX_W             = 15;
	localparam int PIXEL_W             = 32;
	localparam int IN_DATA_W           = 80;
	localparam int CFG_INDEX_W         = 1;
	localparam int QUEUE_DEPTH         = 4;
	localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int PUSH_CNT_W          = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BLEND_ENABLE = 1'b0,
		REG_BLEED_ENABLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last;
	} result_t;

	// Up to two results are written into the output queue per pixel.
	typedef struct packed {
		logic [PUSH_CNT_W-1:0] count;
		result_t               first;
		result_t               second;
	} push_t;

	// Per-byte floor average, no carry between bytes.
	function automatic logic [PIXEL_W-1:0] avg_bytes(input logic [PIXEL_W-1:0] x,
		input logic [PIXEL_W-1:0] y);
		logic [8:0]         sum;
		logic [PIXEL_W-1:0] res;
		for (int b = 0; b < PIXEL_W / 8; b++) begin
			sum = {1'b0, x[b*8 +: 8]} + {1'b0, y[b*8 +: 8]};
			res[b*8 +: 8] = sum[8:1];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/pbb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/pbb_result_queue.sv
// Small output queue that takes up to two results per cycle and hands out one beat.
`default_nettype none

module pbb_result_queue
	import pbb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire push_t                  push,
	input  wire logic                   pop_ready,
	output logic                        out_valid,
	output result_t                     out_item,
	output logic      [QUEUE_CNT_W-1:0] count
);

	result_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic [QUEUE_PTR_W-1:0] wr_ptr_next1;
	logic                   pop;

	assign out_valid    = (count_q != '0);
	assign out_item     = entries_q[rd_ptr_q];
	assign count        = count_q;
	assign pop          = out_valid && pop_ready;
	assign wr_ptr_next1 = wr_ptr_q + QUEUE_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != '0) begin
			entries_q[wr_ptr_q] <= push.first;
		end
		if (push.count == PUSH_CNT_W'(2)) begin
			entries_q[wr_ptr_next1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			count_q <= count_q + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/palette_blend_bleed_pixel_stream.sv
// Top level of the palette lookup, interframe blend and color bleed pixel path.
//
// Input beats arrive on the s_ channel. s_tuser high marks a palette write that
// stores entry_value at color_index; s_tuser low marks a pixel whose color_index
// is looked up. s_tlast marks the last pixel of a line. Results leave on the m_
// channel as one ARGB8888 word per beat, m_tlast on the last pixel of a line.
// Two configuration bits, blend and bleed enable, come on the cfg_ channel; the user,
// not the block, must write them only while the path is idle. cfg_ready is always high.
// A pixel accepted at one edge reads the palette memory at that edge, is finished
// in the next cycle and is written into a four-entry output queue at the following
// edge, from which its first result is offered. With bleed on, a pixel waits in
// a one-pixel hold until its right neighbor arrives. Up to one item is accepted
// every cycle while s_tready is high; the single read port of the palette memory
// handles one pixel per cycle. s_tready drops when the output queue could not
// hold the results of the item in flight plus two more, as can happen after a
// pixel that releases two results, such as an end-of-line pixel with bleed on,
// or when the receiver stalls and results pile up in the queue.
// Reset clears the hold, the configuration bits and the queue; palette contents
// are not cleared and must be written before they are read.
`default_nettype none

module palette_blend_bleed_pixel_stream
	import pbb_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// color_index[14:0], entry_value[46:15], prev_pixel[78:47], prev_valid[79]
	input  wire logic [IN_DATA_W-1:0]   s_tdata,
	// req_type
	input  wire logic                   s_tuser,
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// out_pixel[31:0]
	output logic      [PIXEL_W-1:0]     m_tdata,
	output logic                        m_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic                   cfg_data
);

	localparam int ADDR_W    = $clog2(PALETTE_ENTRIES);
	localparam int IDX_EXT_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
	localparam int READY_W   = QUEUE_CNT_W + 1;

	logic [INDEX_W-1:0]   in_color_index;
	logic [PIXEL_W-1:0]   in_entry_value;
	logic [PIXEL_W-1:0]   in_prev_pixel;
	logic                 in_prev_valid;
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 in_range;
	logic                 s_accept;
	logic                 pix_accept;

	logic                 blend_q;
	logic                 bleed_q;

	logic                 pix_valid_s1;
	logic [PIXEL_W-1:0]   prev_pixel_s1;
	logic                 prev_valid_s1;
	logic                 eol_s1;
	logic                 in_range_s1;

	logic [PIXEL_W-1:0]   held_pixel_q;
	logic                 held_valid_q;

	logic [PIXEL_W-1:0]   ram_rdata;
	logic [PIXEL_W-1:0]   lookup;
	logic [PIXEL_W-1:0]   blended;
	logic                 emit_cur;
	push_t                push;
	result_t              out_item;
	logic [QUEUE_CNT_W-1:0] queue_count;

	assign in_color_index = s_tdata[14:0];
	assign in_entry_value = s_tdata[46:15];
	assign in_prev_pixel  = s_tdata[78:47];
	assign in_prev_valid  = s_tdata[79];

	assign idx_ext    = IDX_EXT_W'(in_color_index);
	assign in_range   = idx_ext < IDX_EXT_W'(PALETTE_ENTRIES);
	assign s_accept   = s_tvalid && s_tready;
	assign pix_accept = s_accept && !s_tuser;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 1'b0;
			bleed_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLEND_ENABLE: blend_q <= cfg_data;
				REG_BLEED_ENABLE: bleed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A write lands at its acceptance edge, so any read accepted after it sees it.
	pbb_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (s_accept && s_tuser && in_range),
		.waddr(idx_ext[ADDR_W-1:0]),
		.wdata(in_entry_value),
		.re   (pix_accept),
		.raddr(idx_ext[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else begin
			pix_valid_s1 <= pix_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			prev_pixel_s1 <= in_prev_pixel;
			prev_valid_s1 <= in_prev_valid;
			eol_s1        <= s_tlast;
			in_range_s1   <= in_range;
		end
	end

	always_comb begin
		lookup   = in_range_s1 ? ram_rdata : '0;
		blended  = (blend_q && prev_valid_s1) ? avg_bytes(prev_pixel_s1, lookup) : lookup;
		emit_cur = !bleed_q || eol_s1;

		push.count = '0;
		if (pix_valid_s1) begin
			push.count = PUSH_CNT_W'(held_valid_q) + PUSH_CNT_W'(emit_cur);
		end
		push.second.pixel = blended;
		push.second.last  = eol_s1;
		if (held_valid_q) begin
			push.first.pixel = avg_bytes(held_pixel_q, blended);
			push.first.last  = 1'b0;
		end else begin
			push.first = push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_pixel_q <= '0;
		end else if (pix_valid_s1) begin
			held_valid_q <= bleed_q && !eol_s1;
			held_pixel_q <= blended;
		end
	end

	pbb_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop_ready(m_tready),
		.out_valid(m_tvalid),
		.out_item (out_item),
		.count    (queue_count)
	);

	assign m_tdata = out_item.pixel;
	assign m_tlast = out_item.last;

	// Room for the results of the pixel in flight plus the worst case of a new one.
	assign s_tready = (READY_W'(queue_count) + READY_W'(push.count) + READY_W'(2))
		<= READY_W'(QUEUE_DEPTH);

endmodule

`default_nettype wire

### rtl/core/pbb_checker.sv
// Port-level checker for the pixel path, bound to the top level.
`default_nettype none

`include "palette_blend_bleed_pixel_stream_assert.svh"

module pbb_checker
	import pbb_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [PIXEL_W-1:0]     m_tdata,
	input wire logic                   m_tlast,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	`PBB_ASSERT(a_out_valid_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped before the beat was taken")

	`PBB_ASSERT_HOLD(a_out_payload_holds, clk, arst_n, m_tvalid, m_tready, {m_tdata, m_tlast}, "stalled output beat changed")

	// A rise of m_tvalid traces back to an accepted input, through the stage-one register and the queue write.
	`PBB_ASSERT(a_out_from_input, clk, arst_n, $rose(m_tvalid) |-> $past(s_acc, 2), "output beat appeared without an accepted input two cycles before")

	`PBB_ASSERT(a_cfg_always_ready, clk, arst_n, cfg_valid |-> cfg_ready, "configuration write was stalled")

endmodule

bind palette_blend_bleed_pixel_stream pbb_checker u_pbb_checker (.*);

`default_nettype wire
